// ----- rtl/core/vtx_pkg.sv -----
// Package for the 4x4 vertex transform: beat types, command codes, register indexes.
// No dependencies.
`default_nettype none
package vtx_pkg;
	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned DOT_W = 68;

	typedef enum logic [1:0] {
		CMD_AFFINE = 2'd0,
		CMD_PROJ = 2'd1,
		CMD_ROTATE = 2'd2,
		CMD_ROT_ALT = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_R0C01 = 3'd0,
		REG_R0C23 = 3'd1,
		REG_R1C01 = 3'd2,
		REG_R1C23 = 3'd3,
		REG_R2C01 = 3'd4,
		REG_R2C23 = 3'd5,
		REG_R3C01 = 3'd6,
		REG_R3C23 = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] command;
		logic signed [31:0] x_in;
		logic signed [31:0] y_in;
		logic signed [31:0] z_in;
		logic last_in_batch;
	} vtx_in_t;

	typedef struct packed {
		logic signed [31:0] x_out;
		logic signed [31:0] y_out;
		logic signed [31:0] z_out;
		logic w_zero;
		logic saturated;
		logic last_out;
	} vtx_out_t;

	typedef struct packed {
		logic [3:0] index;
		logic [63:0] data;
	} cfg_wr_t;

	// per-beat control carried down the pipe
	typedef struct packed {
		logic proj;
		logic last;
	} vtx_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/core/vertex_transform_4x4.sv -----
// Top level of the 4x4 vertex transform: config registers, dot lanes, divider, output.
// Depends on vtx_pkg, vtx_dot, vtx_div.
`default_nettype none
// Streaming Q16.16 vertex transform. One vector accepted per cycle with ready held
// high unless the output register is full and stalled; every stage advances together
// under one enable, so a stall holds the whole pipe. The stages are the dot product
// (multiply, then sum and round), one divider input register, one stage per quotient
// bit (33 + FRAC_BITS), and the output register. Affine and rotate beats
// take the same path so results stay in order. Matrix writes take effect for beats
// accepted after the write; write only while the pipe is empty.
module vertex_transform_4x4 import vtx_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire vtx_in_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output vtx_out_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire cfg_wr_t cfg_data
);
	localparam int DIV_LAT = 32 + FRAC_BITS + 2;
	localparam int LAT = 2 + DIV_LAT;
	localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

	logic [63:0] cfg_q [NUM_REGS];
	logic en;
	logic [LAT-1:0] vld_q;
	vtx_ctl_t ctl_q [LAT];
	logic signed [DOT_W-1:0] dot [4];
	logic signed [31:0] dq [3];
	logic dsat [3];
	logic wz;

	assign cfg_ready = 1'b1;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
			cfg_q[REG_R0C01] <= 64'(ONE);
			cfg_q[REG_R1C01] <= {ONE, 32'd0};
			cfg_q[REG_R2C23] <= 64'(ONE);
			cfg_q[REG_R3C23] <= {ONE, 32'd0};
		end else if (cfg_valid && cfg_data.index[3] == 1'b0) begin
			cfg_q[cfg_data.index[2:0]] <= cfg_data.data;
		end
	end

	logic with_t;
	assign with_t = !in_data.command[1];
	for (genvar r = 0; r < 4; r++) begin : g_row
		vtx_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
			.clk(clk), .en1(en), .en2(en),
			.m0(cfg_q[2*r][31:0]), .m1(cfg_q[2*r][63:32]),
			.m2(cfg_q[2*r+1][31:0]), .m3(cfg_q[2*r+1][63:32]),
			.with_t(with_t), .x(in_data.x_in), .y(in_data.y_in), .z(in_data.z_in),
			.dot(dot[r])
		);
	end

	// w==0 is replaced with 1 in every beat so the divider stays defined
	logic signed [DOT_W-1:0] den;
	assign den = (dot[3] == '0) ? DOT_W'(1) : dot[3];
	logic signed [DOT_W-1:0] dl_s [3][DIV_LAT];
	logic wz_s [DIV_LAT];
	for (genvar c = 0; c < 3; c++) begin : g_col
		vtx_div #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk(clk), .en(en), .num(dot[c]), .den(den), .quo(dq[c]), .sat(dsat[c])
		);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				dl_s[c][0] <= dot[c];
				for (int k = 1; k < DIV_LAT; k++) dl_s[c][k] <= dl_s[c][k-1];
			end
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			wz_s[0] <= dot[3] == '0;
			for (int k = 1; k < DIV_LAT; k++) wz_s[k] <= wz_s[k-1];
		end
	end
	assign wz = wz_s[DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_q[0] <= '{proj: in_data.command == CMD_PROJ, last: in_data.last_in_batch};
			for (int k = 1; k < LAT; k++) ctl_q[k] <= ctl_q[k-1];
		end
	end

	vtx_out_t res;
	always_comb begin
		logic s;
		logic signed [DOT_W-1:0] v;
		res = '0;
		res.last_out = ctl_q[LAT-1].last;
		s = 1'b0;
		if (ctl_q[LAT-1].proj && wz) begin
			res.w_zero = 1'b1;
			s = 1'b1;
			res.x_out = dl_s[0][DIV_LAT-1][DOT_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			res.y_out = dl_s[1][DIV_LAT-1][DOT_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			res.z_out = dl_s[2][DIV_LAT-1][DOT_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else if (ctl_q[LAT-1].proj) begin
			res.x_out = dq[0];
			res.y_out = dq[1];
			res.z_out = dq[2];
			s = dsat[0] || dsat[1] || dsat[2];
		end else begin
			for (int c = 0; c < 3; c++) begin
				v = dl_s[c][DIV_LAT-1];
				if (v > DOT_W'(32'sh7FFF_FFFF)) begin
					s = 1'b1;
					v = DOT_W'(32'sh7FFF_FFFF);
				end else if (v < DOT_W'(32'sh8000_0000)) begin
					s = 1'b1;
					v = DOT_W'(32'sh8000_0000);
				end
				case (c)
					0: res.x_out = v[31:0];
					1: res.y_out = v[31:0];
					default: res.z_out = v[31:0];
				endcase
			end
		end
		res.saturated = s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_q[LAT-1];
		end
	end
	always_ff @(posedge clk) begin
		if (en) out_data <= res;
	end

`ifndef SYNTHESIS
	a_wz_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.w_zero |-> out_data.saturated) else $error("w_zero without sat");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q)) else $error("pipe moved during stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("ready low with empty output");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/vtx_dot.sv -----
// Four-lane dot product of one matrix row with (x, y, z, 1), or (x, y, z, 0) if with_t is low, rounded to FRAC_BITS.
// Two register stages: products, then sum and round. Depends on vtx_pkg.
`default_nettype none
module vtx_dot import vtx_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic en1,
	input wire logic en2,
	input wire logic signed [31:0] m0,
	input wire logic signed [31:0] m1,
	input wire logic signed [31:0] m2,
	input wire logic signed [31:0] m3,
	input wire logic with_t,
	input wire logic signed [31:0] x,
	input wire logic signed [31:0] y,
	input wire logic signed [31:0] z,
	output logic signed [DOT_W-1:0] dot
);
	logic signed [63:0] px_s1, py_s1, pz_s1, pt_s1;
	logic signed [DOT_W-1:0] sum;

	always_ff @(posedge clk) begin
		if (en1) begin
			px_s1 <= m0 * x;
			py_s1 <= m1 * y;
			pz_s1 <= m2 * z;
			pt_s1 <= with_t ? (64'(m3) <<< FRAC_BITS) : '0;
		end
	end

	// exact sum at 2*FRAC_BITS, add half LSB, floor
	assign sum = DOT_W'(px_s1) + DOT_W'(py_s1) + DOT_W'(pz_s1) + DOT_W'(pt_s1)
		+ (DOT_W'(1) <<< (FRAC_BITS - 1));

	always_ff @(posedge clk) begin
		if (en2) begin
			dot <= sum >>> FRAC_BITS;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/vtx_div.sv -----
// Pipelined restoring divider: signed numerator over signed w, FRAC_BITS fraction
// bits, round half away from zero, saturate. One quotient bit per stage. Depends on vtx_pkg.
`default_nettype none
module vtx_div import vtx_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic en,
	input wire logic signed [DOT_W-1:0] num,
	input wire logic signed [DOT_W-1:0] den,
	output logic signed [31:0] quo,
	output logic sat
);
	// quotient bits needed: 32 integer bits + FRAC_BITS + 1 round bit
	localparam int QB = 32 + FRAC_BITS + 1;
	localparam int UW = DOT_W;
	localparam int RW = UW + 1;
	localparam int NW = QB;

	logic [NW-1:0] n_s [QB+1];
	logic [RW-1:0] r_s [QB+1];
	logic [UW-1:0] d_s [QB+1];
	logic [QB-1:0] q_s [QB+1];
	logic neg_s [QB+1];

	logic [UW-1:0] un, ud;
	assign un = num[DOT_W-1] ? UW'(-num) : UW'(num);
	assign ud = den[DOT_W-1] ? UW'(-den) : UW'(den);

	// dividend is un << (FRAC_BITS + 1); everything above its low QB bits seeds the
	// remainder, which stays below ud whenever the integer quotient is under 2^31
	logic [UW-1:0] hi_part;
	assign hi_part = un >> (QB - FRAC_BITS - 1);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0] <= QB'(un) << (FRAC_BITS + 1);
			r_s[0] <= RW'(hi_part);
			d_s[0] <= ud;
			q_s[0] <= '0;
			neg_s[0] <= num[DOT_W-1] ^ den[DOT_W-1];
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [RW-1:0] rt;
		logic [RW-1:0] rn;
		logic ge;
		assign rt = {r_s[k][RW-2:0], n_s[k][NW-1]};
		assign ge = rt >= RW'(d_s[k]);
		assign rn = ge ? rt - RW'(d_s[k]) : rt;
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k+1] <= rn;
				n_s[k+1] <= n_s[k] << 1;
				d_s[k+1] <= d_s[k];
				q_s[k+1] <= {q_s[k][QB-2:0], ge};
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	// integer quotient of 2^31 or more saturates; the seeded pipe is invalid then
	logic ovf_q;
	always_comb begin
		ovf_q = 1'b0;
		// quotient >= 2^31 iff un >= ud * 2^31
		if ((RW+32)'(un) >= ((RW+32)'(ud) << 31)) ovf_q = 1'b1;
	end
	logic ovf_s [QB+1];
	always_ff @(posedge clk) begin
		if (en) ovf_s[0] <= ovf_q;
	end
	for (genvar k = 0; k < QB; k++) begin : g_ovf
		always_ff @(posedge clk) begin
			if (en) ovf_s[k+1] <= ovf_s[k];
		end
	end

	logic [QB-1:0] qf;
	logic [QB-1:0] qr;
	logic signed [QB:0] qs;
	assign qf = q_s[QB];
	assign qr = (qf >> 1) + QB'(qf[0]);
	assign qs = neg_s[QB] ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
	always_comb begin
		sat = 1'b0;
		quo = qs[31:0];
		if (ovf_s[QB]) begin
			sat = 1'b1;
			quo = neg_s[QB] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else if (qs > $signed((QB+1)'(32'h7FFF_FFFF))) begin
			sat = 1'b1;
			quo = 32'sh7FFF_FFFF;
		end else if (qs < -$signed((QB+1)'(33'h0_8000_0000))) begin
			sat = 1'b1;
			quo = 32'sh8000_0000;
		end
	end
endmodule
`default_nettype wire
